@@ design/cpd_pkg.sv @@
package cpd_pkg;

  localparam int unsigned POS_W  = 9;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned SUM_W  = 16;

  // Header bytes that open every frame.
  localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'hEF;
  localparam logic [BYTE_W-1:0] HDR_SECOND = 8'h01;

  // Fixed positions within a frame.
  localparam logic [POS_W-1:0] POS_HDR_FIRST  = 9'd0;
  localparam logic [POS_W-1:0] POS_HDR_SECOND = 9'd1;
  localparam logic [POS_W-1:0] POS_TYPE       = 9'd6;
  localparam logic [POS_W-1:0] POS_LEN_LOW    = 9'd8;
  localparam logic [POS_W-1:0] POS_PAYLOAD    = 9'd9;

  // Shortest legal length: the two checksum bytes alone.
  localparam logic [BYTE_W-1:0] LEN_MIN = 8'd2;

  typedef enum logic [1:0] {
    ST_BUSY  = 2'd0,
    ST_GOOD  = 2'd1,
    ST_ERROR = 2'd2
  } status_t;

  typedef struct packed {
    status_t             status;
    logic [POS_W-1:0]    position;
    logic [BYTE_W-1:0]   value;
  } result_t;

endpackage

@@ design/cpd_parser.sv @@
module cpd_parser
  import cpd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic [BYTE_W-1:0] rx_byte,
  output result_t           result
);

  logic [POS_W-1:0]  position_count, position_count_next;
  logic [BYTE_W-1:0] length_low, length_low_next;
  logic [SUM_W-1:0]  running_sum, running_sum_next;
  logic [BYTE_W-1:0] checksum_high, checksum_high_next;

  logic [SUM_W-1:0]  sum_add;
  logic [POS_W:0]    pos_ext;
  logic [POS_W:0]    len_ext;
  status_t           status;

  assign sum_add = running_sum + {{(SUM_W-BYTE_W){1'b0}}, rx_byte};
  assign pos_ext = {1'b0, position_count};
  assign len_ext = {{(POS_W+1-BYTE_W){1'b0}}, length_low};

  always_comb begin
    status              = ST_BUSY;
    position_count_next = position_count;
    length_low_next     = length_low;
    running_sum_next    = running_sum;
    checksum_high_next  = checksum_high;
    priority if (position_count == POS_HDR_FIRST) begin
      running_sum_next = '0;
      if (rx_byte == HDR_FIRST) begin
        position_count_next = POS_HDR_SECOND;
      end else begin
        status = ST_ERROR;
      end
    end else if (position_count == POS_HDR_SECOND) begin
      if (rx_byte == HDR_SECOND) begin
        position_count_next = position_count + 9'd1;
      end else begin
        status              = ST_ERROR;
        position_count_next = POS_HDR_FIRST;
        running_sum_next    = '0;
      end
    end else if (position_count < POS_TYPE) begin
      position_count_next = position_count + 9'd1;
    end else if (position_count < POS_LEN_LOW) begin
      running_sum_next    = sum_add;
      position_count_next = position_count + 9'd1;
    end else if (position_count == POS_LEN_LOW) begin
      length_low_next = rx_byte;
      if (rx_byte < LEN_MIN) begin
        status              = ST_ERROR;
        position_count_next = POS_HDR_FIRST;
        running_sum_next    = '0;
      end else begin
        running_sum_next    = sum_add;
        position_count_next = POS_PAYLOAD;
      end
    end else if (pos_ext <= len_ext + 10'd6) begin
      running_sum_next    = sum_add;
      position_count_next = position_count + 9'd1;
    end else if (pos_ext == len_ext + 10'd7) begin
      checksum_high_next  = rx_byte;
      position_count_next = position_count + 9'd1;
    end else begin
      status              = ({checksum_high, rx_byte} == running_sum) ? ST_GOOD : ST_ERROR;
      position_count_next = POS_HDR_FIRST;
      running_sum_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position_count <= '0;
      length_low     <= '0;
      running_sum    <= '0;
      checksum_high  <= '0;
    end else if (advance) begin
      position_count <= position_count_next;
      length_low     <= length_low_next;
      running_sum    <= running_sum_next;
      checksum_high  <= checksum_high_next;
    end
  end

  assign result.status   = status;
  assign result.position = position_count;
  assign result.value    = rx_byte;

endmodule

@@ design/cpd_out_stage.sv @@
module cpd_out_stage
  import cpd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t result_in,
  input  logic    out_stall,
  output logic    out_valid,
  output logic    room,
  output result_t result_out
);

  logic valid;

  // The register can take a new result when empty or when its item leaves now.
  assign room      = !valid || !out_stall;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (room) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (room && load) begin
      result_out <= result_in;
    end
  end

endmodule

@@ design/checksummed_packet_deframer.sv @@
// Channel  | Handshake            | Payload
// ---------+----------------------+-------------------------------------------
// input    | in_valid / in_stall  | rx_byte
// output   | out_valid / out_stall| frame_status, byte_position, byte_value
//
// An item is accepted into the input register, and its result is loaded into the
// result register whenever that register has room, and leaves from there;
// with no stalls one item is accepted in every cycle.
// Reset (rst, synchronous) empties both registers and returns the parser to
// the first header byte with a cleared sum. A stall on the output holds the
// result register, and the input register fills behind it before in_stall rises.
module checksummed_packet_deframer
  import cpd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] rx_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        frame_status,
  output logic [POS_W-1:0]  byte_position,
  output logic [BYTE_W-1:0] byte_value
);

  // Input register: holds one received byte until the parser can take it.
  logic              in_held;
  logic [BYTE_W-1:0] in_byte;

  logic    room;
  logic    advance;
  result_t parsed;
  result_t shown;

  // The held byte moves on whenever the result register has room for it.
  assign advance  = in_held && room;
  // The input register accepts when empty or when its item moves on now.
  assign in_stall = in_held && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_held <= 1'b0;
    end else if (!in_stall) begin
      in_held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte <= rx_byte;
    end
  end

  // Frame tracking and checksum: state advances once per item passed on.
  cpd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .rx_byte (in_byte),
    .result  (parsed)
  );

  // Result register, decoupling the parser from a stalled receiver.
  cpd_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (in_held),
    .result_in  (parsed),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .room       (room),
    .result_out (shown)
  );

  assign frame_status  = shown.status;
  assign byte_position = shown.position;
  assign byte_value    = shown.value;

endmodule
